### sv/dsf_pkg.sv
`timescale 1ns / 1ps

package dsf_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int THR_W     = 15;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic        [15:0] box_width;
        logic        [15:0] box_height;
        logic        [15:0] score;
        logic               list_end;
    } t_box_req;

    typedef struct packed {
        logic signed [15:0] kept_x;
        logic signed [15:0] kept_y;
        logic        [15:0] kept_width;
        logic        [15:0] kept_height;
        logic        [15:0] kept_score;
        logic               last_kept;
        logic               overflowed;
    } t_box_res;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_i_en;
        logic [IDX_W-1:0] addr_i;
        logic             issue_j;
        logic [IDX_W-1:0] addr_j;
        logic             load_out;
        logic             last_kept;
        logic             overflowed;
    } t_dsf_cmd;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_dsf_sts;

endpackage

### sv/dsf_dp.sv
`timescale 1ns / 1ps

module dsf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dsf_pkg::t_box_req             i_req,
    input  logic                          i_cfg_valid,
    input  logic [dsf_pkg::THR_W-1:0]     i_cfg_data,
    input  dsf_pkg::t_dsf_cmd             i_cmd,
    output dsf_pkg::t_dsf_sts             o_sts,
    output dsf_pkg::t_box_res             o_res
);

    logic [31:0] r_corner_mem [dsf_pkg::MAX_BOXES];
    logic [31:0] r_size_mem   [dsf_pkg::MAX_BOXES];
    logic [15:0] r_score_mem  [dsf_pkg::MAX_BOXES];

    logic [dsf_pkg::THR_W-1:0]   r_thr;
    logic [2*dsf_pkg::THR_W-1:0] r_thr2;

    logic [31:0] r_cur_corner;
    logic [31:0] r_cur_size;
    logic [15:0] r_cur_score;

    logic [31:0] r_j_corner;
    logic [15:0] r_j_score;
    logic        r_v1;

    logic [32:0] r_dx2;
    logic [32:0] r_dy2;
    logic        r_score_ok;
    logic        r_v2;

    logic        r_hit;
    dsf_pkg::t_box_res r_res;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx2_s;
    logic signed [33:0] dy2_s;
    logic        [33:0] d2;
    logic               close_hit;

    always_comb begin
        dx    = $signed({r_cur_corner[31], r_cur_corner[31:16]})
              - $signed({r_j_corner[31], r_j_corner[31:16]});
        dy    = $signed({r_cur_corner[15], r_cur_corner[15:0]})
              - $signed({r_j_corner[15], r_j_corner[15:0]});
        dx2_s = dx * dx;
        dy2_s = dy * dy;
        d2    = {1'b0, r_dx2} + {1'b0, r_dy2};
        close_hit = r_v2 && r_score_ok && (d2 <= {4'b0, r_thr2});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_corner_mem[i_cmd.wr_addr] <= {i_req.box_x, i_req.box_y};
            r_size_mem[i_cmd.wr_addr]   <= {i_req.box_width, i_req.box_height};
            r_score_mem[i_cmd.wr_addr]  <= i_req.score;
        end
        if (i_cmd.rd_i_en) begin
            r_cur_corner <= r_corner_mem[i_cmd.addr_i];
            r_cur_size   <= r_size_mem[i_cmd.addr_i];
            r_cur_score  <= r_score_mem[i_cmd.addr_i];
        end
        r_j_corner <= r_corner_mem[i_cmd.addr_j];
        r_j_score  <= r_score_mem[i_cmd.addr_j];
    end

    always_ff @(posedge i_clk) begin
        r_dx2      <= dx2_s[32:0];
        r_dy2      <= dy2_s[32:0];
        r_score_ok <= (r_cur_score <= r_j_score);
        r_thr2     <= r_thr * r_thr;
        if (i_cmd.load_out) begin
            r_res.kept_x      <= r_cur_corner[31:16];
            r_res.kept_y      <= r_cur_corner[15:0];
            r_res.kept_width  <= r_cur_size[31:16];
            r_res.kept_height <= r_cur_size[15:0];
            r_res.kept_score  <= r_cur_score;
            r_res.last_kept   <= i_cmd.last_kept;
            r_res.overflowed  <= i_cmd.overflowed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            r_v1 <= i_cmd.issue_j;
            r_v2 <= r_v1;
            if (i_cmd.rd_i_en) begin
                r_hit <= 1'b0;
            end else if (close_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_sts.busy = r_v1 | r_v2;
    assign o_sts.hit  = r_hit;
    assign o_res      = r_res;

endmodule

### sv/dsf_ctrl.sv
`timescale 1ns / 1ps

module dsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_list_end,
    output logic              o_req_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    input  dsf_pkg::t_dsf_sts i_sts,
    output dsf_pkg::t_dsf_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RDI,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [dsf_pkg::CNT_W-1:0] r_count;
    logic [dsf_pkg::CNT_W-1:0] r_i;
    logic [dsf_pkg::CNT_W-1:0] r_j;
    logic                      r_ovf;
    logic                      r_res_valid;

    logic accept;
    logic has_room;
    logic last_i;
    logic issue;

    always_comb begin
        accept   = (r_state == S_LOAD) && i_req_valid;
        has_room = r_count < dsf_pkg::CNT_W'(dsf_pkg::MAX_BOXES);
        last_i   = (r_i + dsf_pkg::CNT_W'(1)) == r_count;
        issue    = (r_state == S_SCAN) && (r_j < r_count) && !i_sts.hit;

        o_cmd.wr_en      = accept && has_room;
        o_cmd.wr_addr    = r_count[dsf_pkg::IDX_W-1:0];
        o_cmd.rd_i_en    = (r_state == S_RDI);
        o_cmd.addr_i     = r_i[dsf_pkg::IDX_W-1:0];
        o_cmd.issue_j    = issue;
        o_cmd.addr_j     = r_j[dsf_pkg::IDX_W-1:0];
        o_cmd.load_out   = (r_state == S_DRAIN) && !i_sts.busy && !i_sts.hit;
        o_cmd.last_kept  = last_i;
        o_cmd.overflowed = r_ovf;
    end

    assign o_req_ready = (r_state == S_LOAD);
    assign o_res_valid = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ovf       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (has_room) begin
                            r_count <= r_count + dsf_pkg::CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_list_end) begin
                            r_i     <= '0;
                            r_state <= S_RDI;
                        end
                    end
                end
                S_RDI: begin
                    r_j     <= r_i + dsf_pkg::CNT_W'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (issue) begin
                        r_j <= r_j + dsf_pkg::CNT_W'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!i_sts.busy) begin
                        if (!i_sts.hit) begin
                            r_res_valid <= 1'b1;
                            r_state     <= S_EMIT;
                        end else begin
                            r_i     <= r_i + dsf_pkg::CNT_W'(1);
                            r_state <= S_RDI;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_res_ready) begin
                        r_res_valid <= 1'b0;
                        if (last_i) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i     <= r_i + dsf_pkg::CNT_W'(1);
                            r_state <= S_RDI;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

### sv/distance_suppression_filter.sv
`timescale 1ns / 1ps

// Corner-distance suppression of detection boxes. Boxes are loaded one per
// cycle into a 64-entry store; a box arriving with the store full is dropped
// and flags every result of its list as overflowed. The box marked list_end
// starts the scan: box i is dropped when a later box has a score at least as
// high and a squared corner distance within the squared threshold. Kept boxes
// leave in input order, the final one marked. For each stored box the scan
// reads that box from the store, then compares it with each later box in turn
// (up to two more compares issue after a hit before the hit is seen), leaves
// the compare loop, drains the compare pipeline and, if the box is kept,
// hands it out, which may stall on the output. The distance
// compare is a three-stage pipeline: store read, difference and square,
// compare. No request is taken during the scan. The threshold register is
// taken at any time; write it while idle.
module distance_suppression_filter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  dsf_pkg::t_box_req         i_req,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output dsf_pkg::t_box_res         o_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dsf_pkg::THR_W-1:0] i_cfg_data
);

    dsf_pkg::t_dsf_cmd cmd;
    dsf_pkg::t_dsf_sts sts;

    assign o_cfg_ready = 1'b1;

    dsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_list_end  (i_req.list_end),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dsf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

import dsf_pkg::*;

class box_scoreboard;
    t_box_req         stored[$];
    bit               lost_boxes;
    logic [THR_W-1:0] threshold;
    t_box_res         kept_q[$];
    int               errors;
    int               checked;
    int               lists;
    int               overflow_lists;

    function new();
        threshold = '0;
        lost_boxes = 0;
        errors = 0;
        checked = 0;
        lists = 0;
        overflow_lists = 0;
    endfunction

    function int pending();
        return kept_q.size();
    endfunction

    function bit within_reach(t_box_req a, t_box_req b);
        longint ax, ay, bx, by, dx, dy, thr;
        ax = a.box_x;
        ay = a.box_y;
        bx = b.box_x;
        by = b.box_y;
        dx = ax - bx;
        dy = ay - by;
        thr = threshold;
        return (dx * dx + dy * dy) <= thr * thr;
    endfunction

    function void note_request(t_box_req b);
        t_box_res r;
        t_box_res held;
        bit       have;
        bit       keep;
        if (stored.size() < MAX_BOXES) begin
            stored = {stored, b};
        end else begin
            lost_boxes = 1;
        end
        if (!b.list_end) begin
            return;
        end
        have = 0;
        for (int i = 0; i < stored.size(); i++) begin
            keep = 1;
            for (int j = i + 1; j < stored.size(); j++) begin
                if (stored[i].score <= stored[j].score && within_reach(stored[i], stored[j])) begin
                    keep = 0;
                    break;
                end
            end
            if (keep) begin
                r.kept_x      = stored[i].box_x;
                r.kept_y      = stored[i].box_y;
                r.kept_width  = stored[i].box_width;
                r.kept_height = stored[i].box_height;
                r.kept_score  = stored[i].score;
                r.last_kept   = 1'b0;
                r.overflowed  = lost_boxes;
                if (have) begin
                    kept_q = {kept_q, held};
                end
                held = r;
                have = 1;
            end
        end
        if (have) begin
            held.last_kept = 1'b1;
            kept_q = {kept_q, held};
        end
        lists++;
        if (lost_boxes) begin
            overflow_lists++;
        end
        stored.delete();
        lost_boxes = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task check_result(t_box_res got);
        t_box_res want;
        if (kept_q.size() == 0) begin
            report($sformatf("kept box with none expected (x=%0d y=%0d)", got.kept_x, got.kept_y));
            return;
        end
        want = kept_q.pop_front();
        checked++;
        if (got.kept_x !== want.kept_x)
            report($sformatf("kept_x got %0d exp %0d", got.kept_x, want.kept_x));
        if (got.kept_y !== want.kept_y)
            report($sformatf("kept_y got %0d exp %0d", got.kept_y, want.kept_y));
        if (got.kept_width !== want.kept_width)
            report($sformatf("kept_width got %0d exp %0d", got.kept_width, want.kept_width));
        if (got.kept_height !== want.kept_height)
            report($sformatf("kept_height got %0d exp %0d", got.kept_height, want.kept_height));
        if (got.kept_score !== want.kept_score)
            report($sformatf("kept_score got %0d exp %0d", got.kept_score, want.kept_score));
        if (got.last_kept !== want.last_kept)
            report($sformatf("last_kept got %b exp %b", got.last_kept, want.last_kept));
        if (got.overflowed !== want.overflowed)
            report($sformatf("overflowed got %b exp %b", got.overflowed, want.overflowed));
    endtask
endclass

module tb_top;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_BOXES = 500;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             req_valid;
    logic             req_ready;
    t_box_req         req;
    logic             res_valid;
    logic             res_ready;
    t_box_res         res;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;

    box_scoreboard sb;
    int            boxes_sent = 0;
    int            cfg_writes = 0;
    int            idle_cycles = 0;

    distance_suppression_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_ready) || (res_valid && res_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_box_req make_box(int x, int y, int s, bit last);
        t_box_req b;
        b.box_x      = x;
        b.box_y      = y;
        b.box_width  = $urandom;
        b.box_height = $urandom;
        b.score      = s;
        b.list_end   = last;
        return b;
    endfunction

    function automatic t_box_req cluster_box(logic [15:0] cx, logic [15:0] cy, int spread,
                                             bit last);
        t_box_req b;
        int       pick;
        b = make_box(0, 0, 0, last);
        if (spread == 0) begin
            b.box_x = $urandom;
            b.box_y = $urandom;
        end else begin
            b.box_x = cx + ($urandom_range(0, 2 * spread) - spread);
            b.box_y = cy + ($urandom_range(0, 2 * spread) - spread);
        end
        pick = $urandom_range(0, 7);
        case (pick)
            0: b.score = 16'h0000;
            1: b.score = 16'hFFFF;
            2: b.score = 16'h8000;
            3: b.score = $urandom_range(0, 3);
            default: b.score = $urandom;
        endcase
        return b;
    endfunction

    // hold valid and payload until the request is taken
    task send_box(t_box_req b, bit quick);
        int gap;
        gap = quick ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req <= b;
        req_valid <= 1'b1;
        do @(posedge i_clk); while (!(req_valid && req_ready));
        sb.note_request(req);
        boxes_sent++;
    endtask

    task wait_idle();
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_threshold(logic [THR_W-1:0] value);
        wait_idle();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        sb.threshold = value;
        cfg_writes++;
    endtask

    task send_list(int n, bit quick);
        logic [15:0] cx;
        logic [15:0] cy;
        int          spread;
        cx = $urandom;
        cy = $urandom;
        case ($urandom_range(0, 4))
            0: spread = 0;
            1: spread = 4;
            2: spread = 32;
            3: spread = 256;
            default: spread = 2048;
        endcase
        for (int k = 0; k < n; k++) begin
            send_box(cluster_box(cx, cy, spread, k == n - 1), quick);
        end
    endtask

    function automatic int list_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 90) return $urandom_range(9, 24);
        if (r < 97) return $urandom_range(25, MAX_BOXES);
        return $urandom_range(MAX_BOXES + 1, MAX_BOXES + 8);
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(1, 400);
            4: return $urandom_range(400, 4000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int lists_in_phase;
        sb = new();
        i_rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // threshold still at its reset value of zero
        send_box(make_box(32767, -32768, 16'hFFFF, 1), 0);
        send_box(make_box(-32768, 32767, 0, 0), 0);
        send_box(make_box(-32768, 32767, 0, 1), 0);
        send_box(make_box(100, 100, 500, 0), 0);
        send_box(make_box(100, 100, 499, 1), 0);
        send_box(make_box(100, 100, 7, 0), 0);
        send_box(make_box(101, 100, 9, 1), 0);

        write_threshold('1);
        send_box(make_box(-32768, 0, 5, 0), 0);
        send_box(make_box(32767, 0, 9, 1), 0);
        send_box(make_box(0, 0, 1, 0), 1);
        send_box(make_box(32767, 0, 1, 1), 1);

        // exactly on the radius, then just outside it
        write_threshold(80);
        send_box(make_box(0, 0, 10, 0), 0);
        send_box(make_box(48, 64, 20, 0), 0);
        send_box(make_box(96, 129, 30, 1), 0);
        send_box(make_box(-5, -7, 40, 0), 1);
        send_box(make_box(-53, -71, 40, 1), 1);

        write_threshold('0);
        while (boxes_sent < RANDOM_BOXES + 17) begin
            write_threshold(pick_threshold());
            lists_in_phase = $urandom_range(2, 8);
            for (int l = 0; l < lists_in_phase; l++) begin
                send_list(list_length(), $urandom_range(0, 3) == 0);
            end
        end
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d boxes in %0d lists (%0d past capacity), %0d threshold writes",
                 boxes_sent, sb.lists, sb.overflow_lists, cfg_writes);
        $display("Checked %0d kept boxes, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        int stall;
        int burst;
        burst = 0;
        res_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (burst > 0) begin
                stall = 0;
                burst--;
            end else begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0) begin
                    burst = $urandom_range(10, 40);
                end
            end
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ready <= 1'b1;
            do @(posedge i_clk); while (!(res_valid && res_ready));
            sb.check_result(res);
        end
    end

endmodule
